[hdl/assert_macros.svh]
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define FPBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// trigger implies consequence in the following cycle
`define FPBA_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) else $error(msg);

`endif

[hdl/fpba_pkg.sv]
// shared types and constants of the fit policy block allocator
`default_nettype none
package fpba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF  = 64;
  localparam int unsigned OFFSET_BITS_DEF = 20;

  localparam int unsigned FIELD_W = 20;
  localparam int unsigned NEED_W  = 21;
  localparam int unsigned HDR_W   = 8;
  localparam int unsigned FRAG_W  = 7;

  localparam logic [FIELD_W-1:0] POOL_RST = 20'd65536;
  localparam logic               MODE_RST = 1'b0;
  localparam logic [HDR_W-1:0]   HDR_RST  = 8'd32;
  localparam logic [FRAG_W-1:0]  FRAG_MAX = 7'd127;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_POOL = 2'd0,
    REG_MODE = 2'd1,
    REG_HDR  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic req;
    logic ok;
  } init_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [FIELD_W-1:0] granted;
    logic [FRAG_W-1:0]  frag;
  } res_t;

endpackage
`default_nettype wire

[hdl/fpba_ram.sv]
// block table memory, one write and one registered read port
`default_nettype none
module fpba_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 41
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/fpba_ctrl.sv]
// command sequencer: table scans, split, merge and entry shifts
`default_nettype none
`include "assert_macros.svh"
module fpba_ctrl import fpba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [FIELD_W-1:0]     request_size_i,
  input  wire logic [FIELD_W-1:0]     payload_offset_i,
  input  wire logic                   fit_mode_i,
  input  wire logic [HDR_W-1:0]       header_i,
  input  wire init_t                  init_i,
  input  wire logic [OFFSET_BITS-1:0] init_pay_i,
  input  wire logic [OFFSET_BITS-1:0] init_size_i,
  input  wire logic                   out_free_i,
  output res_t                        res_o
);

  localparam int unsigned W    = OFFSET_BITS;
  localparam int unsigned EW   = 2 * W + 1;
  localparam int unsigned IDXW = $clog2(MAX_BLOCKS);
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW   = ((W > NEED_W + 1) ? W : NEED_W + 1) + 1;
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DEC, S_SHIFT, S_WR_REM, S_WR_PICK, S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic                init_pend_q, init_pend_d;
  logic [W-1:0]        init_pay_q, init_pay_d, init_size_q, init_size_d;
  cmd_e                cmd_q, cmd_d;
  logic [NEED_W-1:0]   need_q, need_d;
  logic [FIELD_W-1:0]  req_q, req_d, off_q, off_d;
  logic [CNTW-1:0]     ptr_q, ptr_d, ridx_q, ridx_d;
  logic                rv_q, rv_d;
  logic                found_q, found_d;
  logic [CNTW-1:0]     pk_idx_q, pk_idx_d;
  logic [W-1:0]        pk_pay_q, pk_pay_d, pk_size_q, pk_size_d;
  logic                last_v_q, last_v_d, last_used_q, last_used_d;
  logic [W-1:0]        last_pay_q, last_pay_d, last_size_q, last_size_d;
  logic                pv_v_q, pv_v_d, pv_used_q, pv_used_d;
  logic [W-1:0]        pv_pay_q, pv_pay_d, pv_size_q, pv_size_d;
  logic                nx_v_q, nx_v_d, nx_used_q, nx_used_d;
  logic [W-1:0]        nx_size_q, nx_size_d;
  logic [FRAG_W-1:0]   frag_q, frag_d;
  logic                sh_up_q, sh_up_d;
  logic [CNTW-1:0]     sh_src_q, sh_src_d, sh_left_q, sh_left_d;
  logic [1:0]          sh_off_q, sh_off_d;
  logic                pw_v_q, pw_v_d;
  logic [CNTW-1:0]     pw_dst_q, pw_dst_d;
  res_t                res_q, res_d;

  logic                we, re;
  logic [IDXW-1:0]     waddr, raddr;
  logic [EW-1:0]       wdata, rdata;

  logic                e_used;
  logic [W-1:0]        e_pay, e_size, hdr_w;
  logic [CW-1:0]       nh;
  logic [NEED_W-1:0]   need_in;
  logic                nm, pm;
  logic [W-1:0]        s1, s2;
  logic [CNTW:0]       src_start;

  fpba_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign e_used  = rdata[2*W];
  assign e_pay   = rdata[2*W-1:W];
  assign e_size  = rdata[W-1:0];
  assign hdr_w   = W'(header_i);
  assign nh      = CW'(need_q) + CW'(header_i);
  assign need_in = (NEED_W'(request_size_i) + NEED_W'(3)) & ~NEED_W'(3);

  // merge of the freed entry with its free neighbors
  assign nm = nx_v_q && !nx_used_q;
  assign pm = pv_v_q && !pv_used_q;
  assign s1 = nm ? (pk_size_q + nx_size_q + hdr_w) : pk_size_q;
  assign s2 = pm ? (pv_size_q + s1 + hdr_w) : s1;
  assign src_start = (CNTW+1)'(pk_idx_q) + (CNTW+1)'(1) + (CNTW+1)'(nm);

  assign in_ready_o = (state_q == S_IDLE) && !init_pend_q;
  assign res_o      = res_q;

  always_comb begin
    state_d = state_q;      cnt_d = cnt_q;
    init_pend_d = init_pend_q; init_pay_d = init_pay_q; init_size_d = init_size_q;
    cmd_d = cmd_q;  need_d = need_q;  req_d = req_q;  off_d = off_q;
    ptr_d = ptr_q;  ridx_d = ridx_q;  rv_d = rv_q;   found_d = found_q;
    pk_idx_d = pk_idx_q; pk_pay_d = pk_pay_q; pk_size_d = pk_size_q;
    last_v_d = last_v_q; last_used_d = last_used_q;
    last_pay_d = last_pay_q; last_size_d = last_size_q;
    pv_v_d = pv_v_q; pv_used_d = pv_used_q; pv_pay_d = pv_pay_q; pv_size_d = pv_size_q;
    nx_v_d = nx_v_q; nx_used_d = nx_used_q; nx_size_d = nx_size_q;
    frag_d = frag_q;
    sh_up_d = sh_up_q; sh_src_d = sh_src_q; sh_left_d = sh_left_q; sh_off_d = sh_off_q;
    pw_v_d = pw_v_q; pw_dst_d = pw_dst_q;
    res_d = res_q;
    res_d.valid = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0;
    re = 1'b0; raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (init_pend_q) begin
          we = 1'b1;
          wdata = {1'b0, init_pay_q, init_size_q};
          init_pend_d = 1'b0;
        end else if (in_valid_i) begin
          cmd_d = cmd_e'(cmd_i);
          req_d = request_size_i;
          off_d = payload_offset_i;
          need_d = need_in;
          ptr_d = '0; rv_d = 1'b0; found_d = 1'b0;
          last_v_d = 1'b0; pv_v_d = 1'b0; nx_v_d = 1'b0; frag_d = '0;
          res_d.status = ST_DONE; res_d.granted = '0; res_d.frag = '0;
          if ((cmd_e'(cmd_i) == CMD_ALLOC && need_in == '0) ||
              cmd_e'(cmd_i) == CMD_RSVD) begin
            res_d.status = ST_NOFIT;
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (ptr_q != cnt_q) begin
          re = 1'b1;
          raddr = ptr_q[IDXW-1:0];
          ptr_d = ptr_q + CNTW'(1);
          rv_d = 1'b1;
          ridx_d = ptr_q;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            state_d = S_DEC;
          end
        end
        if (rv_q) begin
          unique case (cmd_q)
            CMD_ALLOC: begin
              if (!e_used && CW'(e_size) >= CW'(need_q) &&
                  (!found_q || (!fit_mode_i && e_size < pk_size_q) ||
                   (fit_mode_i && e_size > pk_size_q))) begin
                found_d = 1'b1; pk_idx_d = ridx_q; pk_pay_d = e_pay; pk_size_d = e_size;
              end
            end
            CMD_FREE: begin
              if (!found_q && e_used && CW'(e_pay) == CW'(off_q)) begin
                found_d = 1'b1; pk_idx_d = ridx_q; pk_pay_d = e_pay; pk_size_d = e_size;
                pv_v_d = last_v_q; pv_used_d = last_used_q;
                pv_pay_d = last_pay_q; pv_size_d = last_size_q;
              end else if (found_q && ridx_q == pk_idx_q + CNTW'(1)) begin
                nx_v_d = 1'b1; nx_used_d = e_used; nx_size_d = e_size;
              end
              last_v_d = 1'b1; last_used_d = e_used;
              last_pay_d = e_pay; last_size_d = e_size;
            end
            CMD_COUNT: begin
              if (!e_used && CW'(e_size) < CW'(req_q) && frag_q != FRAG_MAX) begin
                frag_d = frag_q + FRAG_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DEC: begin
        unique case (cmd_q)
          CMD_ALLOC: begin
            if (!found_q) begin
              res_d.status = ST_NOFIT;
              state_d = S_DONE;
            end else begin
              res_d.granted = FIELD_W'(pk_pay_q);
              if (CW'(pk_size_q) >= nh && cnt_q != CNT_MAX) begin
                // split: open a slot after the pick by moving the tail up
                sh_up_d = 1'b1;
                sh_src_d = cnt_q - CNTW'(1);
                sh_left_d = cnt_q - CNTW'(1) - pk_idx_q;
                pw_v_d = 1'b0;
                cnt_d = cnt_q + CNTW'(1);
                state_d = S_SHIFT;
              end else begin
                we = 1'b1;
                waddr = pk_idx_q[IDXW-1:0];
                wdata = {1'b1, pk_pay_q, pk_size_q};
                state_d = S_DONE;
              end
            end
          end
          CMD_FREE: begin
            if (!found_q) begin
              res_d.status = ST_NOTFOUND;
              state_d = S_DONE;
            end else begin
              we = 1'b1;
              waddr = pm ? IDXW'(pk_idx_q - CNTW'(1)) : pk_idx_q[IDXW-1:0];
              wdata = {1'b0, pm ? pv_pay_q : pk_pay_q, s2};
              // close the gap left by merged entries
              sh_up_d = 1'b0;
              sh_src_d = CNTW'(src_start);
              sh_left_d = (src_start < (CNTW+1)'(cnt_q)) ?
                          CNTW'((CNTW+1)'(cnt_q) - src_start) : '0;
              sh_off_d = 2'(nm) + 2'(pm);
              pw_v_d = 1'b0;
              cnt_d = cnt_q - CNTW'(nm) - CNTW'(pm);
              state_d = S_SHIFT;
            end
          end
          default: begin
            res_d.frag = frag_q;
            state_d = S_DONE;
          end
        endcase
      end

      S_SHIFT: begin
        if (pw_v_q) begin
          we = 1'b1;
          waddr = pw_dst_q[IDXW-1:0];
          wdata = rdata;
        end
        if (sh_left_q != '0) begin
          re = 1'b1;
          raddr = sh_src_q[IDXW-1:0];
          pw_v_d = 1'b1;
          pw_dst_d = sh_up_q ? sh_src_q + CNTW'(1) : sh_src_q - CNTW'(sh_off_q);
          sh_src_d = sh_up_q ? sh_src_q - CNTW'(1) : sh_src_q + CNTW'(1);
          sh_left_d = sh_left_q - CNTW'(1);
        end else begin
          pw_v_d = 1'b0;
          if (!pw_v_q) begin
            state_d = sh_up_q ? S_WR_REM : S_DONE;
          end
        end
      end

      S_WR_REM: begin
        we = 1'b1;
        waddr = IDXW'(pk_idx_q + CNTW'(1));
        wdata = {1'b0, W'(CW'(pk_pay_q) + nh), W'(CW'(pk_size_q) - nh)};
        state_d = S_WR_PICK;
      end

      S_WR_PICK: begin
        we = 1'b1;
        waddr = pk_idx_q[IDXW-1:0];
        wdata = {1'b1, pk_pay_q, W'(need_q)};
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free_i) begin
          res_d.valid = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // pool write reloads the table as one free block, or empties it when the pool is smaller than the header
    if (init_i.req) begin
      cnt_d = init_i.ok ? CNTW'(1) : '0;
      init_pend_d = init_i.ok;
      init_pay_d = init_pay_i;
      init_size_d = init_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= CNTW'(1);
      init_pend_q <= 1'b1;
      init_pay_q <= W'(HDR_RST);
      init_size_q <= W'(POOL_RST - FIELD_W'(HDR_RST));
      rv_q <= 1'b0;
      pw_v_q <= 1'b0;
      res_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      init_pend_q <= init_pend_d;
      init_pay_q <= init_pay_d;
      init_size_q <= init_size_d;
      rv_q <= rv_d;
      pw_v_q <= pw_v_d;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; need_q <= need_d; req_q <= req_d; off_q <= off_d;
    ptr_q <= ptr_d; ridx_q <= ridx_d; found_q <= found_d;
    pk_idx_q <= pk_idx_d; pk_pay_q <= pk_pay_d; pk_size_q <= pk_size_d;
    last_v_q <= last_v_d; last_used_q <= last_used_d;
    last_pay_q <= last_pay_d; last_size_q <= last_size_d;
    pv_v_q <= pv_v_d; pv_used_q <= pv_used_d; pv_pay_q <= pv_pay_d; pv_size_q <= pv_size_d;
    nx_v_q <= nx_v_d; nx_used_q <= nx_used_d; nx_size_q <= nx_size_d;
    frag_q <= frag_d;
    sh_up_q <= sh_up_d; sh_src_q <= sh_src_d; sh_left_q <= sh_left_d; sh_off_q <= sh_off_d;
    pw_dst_q <= pw_dst_d;
  end

  `FPBA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_MAX, "block count above table depth")
  `FPBA_ASSERT(a_no_rw_clash, clk_i, rst_ni, !(we && re && waddr == raddr),
    "table read and write hit the same entry")
  `FPBA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o,
    state_q == S_SCAN || state_q == S_DONE, "accepted item did not start")

endmodule
`default_nettype wire

[hdl/fit_policy_block_allocator_core.sv]
// top level: configuration registers, sequencer and result register
//
// Pool allocator with best or worst fit and coalescing on free. Each item is
// one command; the block takes one item at a time and answers with exactly one
// result. The table sits in a memory with one read and one write port, so an
// item takes one scan read per table entry in use, then one read per entry
// moved up or down. After reset and after each pool_bytes write that is not
// smaller than the header, the first table entry is rewritten before the next
// item is taken. The finished result is held in an output register, so the
// next item is accepted while it waits to be taken.
`default_nettype none
module fit_policy_block_allocator_core import fpba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [FIELD_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [FIELD_W-1:0] request_size_i,
  input  wire logic [FIELD_W-1:0] payload_offset_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [FIELD_W-1:0]      granted_offset_o,
  output logic [FRAG_W-1:0]       fragment_count_o
);

  logic               mode_q, mode_d;
  logic [HDR_W-1:0]   hdr_q, hdr_d;
  init_t              init;
  logic [OFFSET_BITS-1:0] init_pay, init_size;
  res_t               res;
  logic               out_v_q, out_v_d;
  logic [1:0]         status_q, status_d;
  logic [FIELD_W-1:0] granted_q, granted_d;
  logic [FRAG_W-1:0]  frag_q, frag_d;

  always_comb begin
    mode_d = mode_q;
    hdr_d = hdr_q;
    init = '0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_POOL: begin
          init.req = 1'b1;
          init.ok = cfg_wdata_i >= FIELD_W'(hdr_q);
        end
        REG_MODE: mode_d = cfg_wdata_i[0];
        REG_HDR:  hdr_d = cfg_wdata_i[HDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign init_pay  = OFFSET_BITS'(hdr_q);
  assign init_size = OFFSET_BITS'(cfg_wdata_i - FIELD_W'(hdr_q));

  fpba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .OFFSET_BITS(OFFSET_BITS)) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .request_size_i   (request_size_i),
    .payload_offset_i (payload_offset_i),
    .fit_mode_i       (mode_q),
    .header_i         (hdr_q),
    .init_i           (init),
    .init_pay_i       (init_pay),
    .init_size_i      (init_size),
    .out_free_i       (!out_v_q || out_ready_i),
    .res_o            (res)
  );

  always_comb begin
    out_v_d = out_v_q;
    status_d = status_q;
    granted_d = granted_q;
    frag_d = frag_q;
    if (res.valid) begin
      out_v_d = 1'b1;
      status_d = res.status;
      granted_d = res.granted;
      frag_d = res.frag;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RST;
      hdr_q <= HDR_RST;
      out_v_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      hdr_q <= hdr_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    granted_q <= granted_d;
    frag_q <= frag_d;
  end

  assign out_valid_o      = out_v_q;
  assign status_o         = status_q;
  assign granted_offset_o = granted_q;
  assign fragment_count_o = frag_q;

endmodule
`default_nettype wire

[tb/alloc_result_checker.sv]
// checker for the block allocator: mirrors the pool table, predicts and compares results
`timescale 1ns / 1ps
`default_nettype none
module alloc_result_checker import fpba_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [FIELD_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [FIELD_W-1:0] request_size_i,
  input  wire logic [FIELD_W-1:0] payload_offset_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [1:0]         status_i,
  input  wire logic [FIELD_W-1:0] granted_offset_i,
  input  wire logic [FRAG_W-1:0]  fragment_count_i,
  output int                      errors_o,
  output int                      pending_o
);

  localparam int NBLK = MAX_BLOCKS_DEF;

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] granted;
    logic [FRAG_W-1:0]  frag;
  } answer_t;

  logic [FIELD_W-1:0] blk_pay  [NBLK];
  logic [FIELD_W-1:0] blk_size [NBLK];
  logic               blk_used [NBLK];
  int                 blk_cnt;
  logic [FIELD_W-1:0] pool_sz;
  logic               worst_fit;
  logic [HDR_W-1:0]   hdr_sz;
  answer_t            answers_due[$];

  task automatic rebuild_pool();
    for (int k = 0; k < NBLK; k++) begin
      blk_pay[k] = '0; blk_size[k] = '0; blk_used[k] = 1'b0;
    end
    if (pool_sz >= FIELD_W'(hdr_sz)) begin
      blk_pay[0]  = FIELD_W'(hdr_sz);
      blk_size[0] = pool_sz - FIELD_W'(hdr_sz);
      blk_cnt = 1;
    end else begin
      blk_cnt = 0;
    end
  endtask

  task automatic drop_entry(input int idx);
    for (int k = idx; k + 1 < blk_cnt; k++) begin
      blk_pay[k] = blk_pay[k+1]; blk_size[k] = blk_size[k+1]; blk_used[k] = blk_used[k+1];
    end
    blk_cnt--;
    blk_pay[blk_cnt] = '0; blk_size[blk_cnt] = '0; blk_used[blk_cnt] = 1'b0;
  endtask

  task automatic apply_command(input logic [1:0] cmd, input logic [FIELD_W-1:0] req,
                               input logic [FIELD_W-1:0] off, output answer_t ans);
    logic [NEED_W-1:0] need;
    int                pick;
    int                idx;
    int                cnt;
    ans = '{status: ST_DONE, granted: '0, frag: '0};
    case (cmd)
      CMD_ALLOC: begin
        need = (NEED_W'(req) + 3) & ~NEED_W'(3);
        pick = -1;
        if (need != 0) begin
          for (int i = 0; i < blk_cnt; i++) begin
            if (blk_used[i] || NEED_W'(blk_size[i]) < need) continue;
            if (pick < 0 || (!worst_fit && blk_size[i] < blk_size[pick]) ||
                (worst_fit && blk_size[i] > blk_size[pick]))
              pick = i;
          end
        end
        if (pick < 0) begin
          ans.status = ST_NOFIT;
        end else begin
          blk_used[pick] = 1'b1;
          if (22'(blk_size[pick]) >= 22'(need) + 22'(hdr_sz) && blk_cnt < NBLK) begin
            for (int k = blk_cnt; k > pick + 1; k--) begin
              blk_pay[k] = blk_pay[k-1]; blk_size[k] = blk_size[k-1]; blk_used[k] = blk_used[k-1];
            end
            blk_pay[pick+1]  = blk_pay[pick] + FIELD_W'(need) + FIELD_W'(hdr_sz);
            blk_size[pick+1] = blk_size[pick] - FIELD_W'(need) - FIELD_W'(hdr_sz);
            blk_used[pick+1] = 1'b0;
            blk_size[pick]   = FIELD_W'(need);
            blk_cnt++;
          end
          ans.granted = blk_pay[pick];
        end
      end
      CMD_FREE: begin
        idx = -1;
        for (int i = 0; i < blk_cnt; i++)
          if (idx < 0 && blk_used[i] && blk_pay[i] == off) idx = i;
        if (idx < 0) begin
          ans.status = ST_NOTFOUND;
        end else begin
          blk_used[idx] = 1'b0;
          if (idx + 1 < blk_cnt && !blk_used[idx+1]) begin
            blk_size[idx] = blk_size[idx] + blk_size[idx+1] + FIELD_W'(hdr_sz);
            drop_entry(idx + 1);
          end
          if (idx > 0 && !blk_used[idx-1]) begin
            blk_size[idx-1] = blk_size[idx-1] + blk_size[idx] + FIELD_W'(hdr_sz);
            drop_entry(idx);
          end
        end
      end
      CMD_COUNT: begin
        cnt = 0;
        for (int i = 0; i < blk_cnt; i++)
          if (!blk_used[i] && blk_size[i] < req && cnt < 127) cnt++;
        ans.frag = FRAG_W'(cnt);
      end
      default: ans.status = ST_NOFIT;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t ans;
    if (!rst_ni) begin
      pool_sz = POOL_RST; worst_fit = MODE_RST; hdr_sz = HDR_RST;
      rebuild_pool();
      answers_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POOL: begin pool_sz = cfg_wdata_i; rebuild_pool(); end
          REG_MODE: worst_fit = cfg_wdata_i[0];
          REG_HDR:  hdr_sz = cfg_wdata_i[HDR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          ans = answers_due.pop_front();
          if (status_i != ans.status) report_mismatch("status", status_i, ans.status);
          if (granted_offset_i != ans.granted)
            report_mismatch("granted_offset", granted_offset_i, ans.granted);
          if (fragment_count_i != ans.frag)
            report_mismatch("fragment_count", fragment_count_i, ans.frag);
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(cmd_i, request_size_i, payload_offset_i, ans);
        answers_due.push_back(ans);
      end
    end
    pending_o = answers_due.size();
  end

endmodule
`default_nettype wire

[tb/fit_policy_block_allocator_core_test.sv]
// testbench top: stimulus, configuration phases and verdict for the block allocator
`timescale 1ns / 1ps
`default_nettype none
module fit_policy_block_allocator_core_test;
  import fpba_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [FIELD_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         cmd_i = '0;
  logic [FIELD_W-1:0] request_size_i = '0;
  logic [FIELD_W-1:0] payload_offset_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [FIELD_W-1:0] granted_offset_o;
  logic [FRAG_W-1:0]  fragment_count_o;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  bit                 quiet = 1'b0;
  int                 stall_left = 0;
  logic [FIELD_W-1:0] live_offsets[$];

  always #10 clk_i = ~clk_i;

  fit_policy_block_allocator_core dut (.*);

  alloc_result_checker check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .request_size_i, .payload_offset_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .granted_offset_i(granted_offset_o), .fragment_count_i(fragment_count_o),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls in bursts unless quiet is set
  always @(posedge clk_i) begin
    logic rdy;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
    rdy = 1'b1;
    if (!quiet) begin
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 9);
        rdy = 1'b0;
      end
    end
    out_ready_i <= rdy;
    // remember granted offsets so frees mostly hit live blocks
    if (out_valid_o && out_ready_i && granted_offset_o != 0)
      live_offsets.push_back(granted_offset_o);
  end

  task automatic send_item(input logic [1:0] cmd, input logic [FIELD_W-1:0] req,
                           input logic [FIELD_W-1:0] off);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    request_size_i <= req;
    payload_offset_i <= off;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [FIELD_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_POOL) live_offsets.delete();
    @(posedge clk_i);
  endtask

  task automatic set_pool(input logic mode, input logic [HDR_W-1:0] hdr,
                          input logic [FIELD_W-1:0] pool);
    drain();
    write_reg(REG_MODE, FIELD_W'(mode));
    write_reg(REG_HDR, FIELD_W'(hdr));
    write_reg(REG_POOL, pool);
  endtask

  function automatic logic [FIELD_W-1:0] pick_live();
    if (live_offsets.size() == 0) return FIELD_W'($urandom);
    return live_offsets[$urandom_range(0, live_offsets.size() - 1)];
  endfunction

  task automatic random_items(input int n, input int max_req);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        send_item(CMD_ALLOC, ($urandom_range(0, 19) == 0) ? FIELD_W'($urandom)
                                                         : FIELD_W'($urandom_range(0, max_req)),
                  FIELD_W'($urandom));
      else if (sel < 80)
        send_item(CMD_FREE, FIELD_W'($urandom),
                  ($urandom_range(0, 9) == 0) ? FIELD_W'($urandom) : pick_live());
      else if (sel < 95)
        send_item(CMD_COUNT, ($urandom_range(0, 4) == 0) ? FIELD_W'($urandom)
                                                        : FIELD_W'($urandom_range(0, max_req)),
                  FIELD_W'($urandom));
      else
        send_item(CMD_RSVD, FIELD_W'($urandom), FIELD_W'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset pool, zero and oversized requests, ties, frees, odd command
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_ALLOC, 20'd1, '0);
    send_item(CMD_ALLOC, 20'hFFFFF, '0);
    send_item(CMD_ALLOC, 20'd100, '0);
    send_item(CMD_ALLOC, 20'd100, '0);
    send_item(CMD_ALLOC, 20'd100, '0);
    send_item(CMD_FREE, '0, 20'd32);
    send_item(CMD_FREE, '0, 20'd32);
    send_item(CMD_FREE, '0, 20'hFFFFF);
    send_item(CMD_ALLOC, 20'd97, '0);
    send_item(CMD_COUNT, 20'hFFFFF, '0);
    send_item(CMD_COUNT, '0, '0);
    send_item(CMD_RSVD, 20'hFFFFF, 20'hFFFFF);

    // pool smaller than one header leaves the table empty
    set_pool(1'b1, 8'd255, 20'd100);
    send_item(CMD_ALLOC, 20'd4, '0);
    send_item(CMD_FREE, '0, 20'd255);
    send_item(CMD_COUNT, 20'd1000, '0);

    // zero header, full pool: fill the table so a splittable block is given whole
    set_pool(1'b0, 8'd0, 20'hFFFFF);
    for (int i = 0; i < 66; i++) send_item(CMD_ALLOC, 20'd4, '0);
    send_item(CMD_COUNT, 20'hFFFFF, '0);
    send_item(CMD_FREE, '0, 20'd4);
    send_item(CMD_FREE, '0, 20'd12);
    send_item(CMD_FREE, '0, 20'd8);

    set_pool(1'b0, 8'd32, 20'd65536);
    random_items(300, 3000);
    set_pool(1'b1, 8'd0, 20'hFFFFF);
    random_items(300, 40000);
    set_pool(1'b0, 8'd255, 20'd4096);
    random_items(250, 600);
    set_pool(1'b1, 8'd8, 20'd2000);
    random_items(250, 200);
    set_pool(1'b0, 8'd4, 20'd0);
    random_items(40, 16);
    set_pool(1'b0, 8'd16, 20'd20000);
    random_items(300, 800);
    set_pool(1'b1, 8'd64, 20'd30000);
    quiet = 1'b1;
    random_items(250, 1500);

    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/fpba_pkg.sv
hdl/fpba_ram.sv
hdl/fpba_ctrl.sv
hdl/fit_policy_block_allocator_core.sv
tb/alloc_result_checker.sv
tb/fit_policy_block_allocator_core_test.sv
